// ===== sv/fmc_pkg.sv =====
// ----------------------------------------------------------------------------
// fmc_pkg
// shared types and constants for the packet rule classifier
// ----------------------------------------------------------------------------
package fmc_pkg;

  localparam int MaxRules     = 32;
  localparam int WordsPerRule = 16;
  localparam int TableDepth   = MaxRules * WordsPerRule;
  localparam int RuleIdxW     = $clog2(MaxRules);
  localparam int WordIdxW     = $clog2(WordsPerRule);
  localparam int AddrW        = $clog2(TableDepth);
  localparam int CountW       = 6;

  localparam logic [2:0] ActAllow    = 3'd0;
  localparam logic [2:0] ActDrop     = 3'd1;
  localparam logic [2:0] ActRedirect = 3'd3;
  localparam logic [2:0] ActSocks5   = 3'd4;
  localparam logic [2:0] ActConnect  = 3'd5;
  localparam logic [1:0] ProtoAny    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WORD,
    ST_EVAL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       start;
    logic       write;
    logic       rd_en;
    logic [3:0] word;
    logic       capture;
    logic       hit_sel;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } sts_t;

endpackage

// ===== sv/fmc_datapath.sv =====
// ----------------------------------------------------------------------------
// fmc_datapath
// rule table memory, packet registers, rule compare and result registers
// ----------------------------------------------------------------------------
module fmc_datapath import fmc_pkg::*; (
  input  logic                clk_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [RuleIdxW-1:0] rule_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  logic [63:0]         wdata_i,
  input  logic                is_ipv6_i,
  input  logic                direction_i,
  input  logic [1:0]          protocol_i,
  input  logic [63:0]         src_addr_high_i,
  input  logic [63:0]         src_addr_low_i,
  input  logic [63:0]         dst_addr_high_i,
  input  logic [63:0]         dst_addr_low_i,
  input  logic [15:0]         src_port_i,
  input  logic [15:0]         dst_port_i,
  output logic [2:0]          action_o,
  output logic [31:0]         proxy_ip4_o,
  output logic [15:0]         proxy_port_o,
  output logic                ip6_given_o,
  output logic [63:0]         redirect_ip6_high_o,
  output logic [63:0]         redirect_ip6_low_o
);

  logic [63:0] mem_q [TableDepth];
  logic [63:0] rdata_q;
  logic [3:0]  rword_q;
  logic [63:0] w_q [13];
  logic        v6_q, dir_q;
  logic [1:0]  proto_q;
  logic [63:0] sh_q, sl_q, dh_q, dl_q;
  logic [15:0] sp_q, dp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[{rule_i, cmd_i.word}];
    end
    rword_q <= cmd_i.word;
    if (cmd_i.capture && rword_q < 4'd13) begin
      w_q[rword_q] <= rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      v6_q    <= is_ipv6_i;
      dir_q   <= direction_i;
      proto_q <= protocol_i;
      sh_q    <= is_ipv6_i ? src_addr_high_i : 64'd0;
      dh_q    <= is_ipv6_i ? dst_addr_high_i : 64'd0;
      sl_q    <= is_ipv6_i ? src_addr_low_i : {32'd0, src_addr_low_i[31:0]};
      dl_q    <= is_ipv6_i ? dst_addr_low_i : {32'd0, dst_addr_low_i[31:0]};
      sp_q    <= src_port_i;
      dp_q    <= dst_port_i;
    end
  end

  logic [63:0] m, hm;
  logic [1:0]  rp;
  logic        src_ok, dst_ok, sp_ok, dp_ok;

  function automatic logic addr_ok(logic [63:0] ph, logic [63:0] pl, logic [63:0] rh,
                                   logic [63:0] rl, logic [63:0] mh, logic [63:0] ml);
    if (mh == 64'd0 && ml == 64'd0) return 1'b1;
    return ((ph & mh) == (rh & mh)) && ((pl & ml) == (rl & ml));
  endfunction

  function automatic logic port_in(logic [15:0] lo, logic [15:0] hi, logic [15:0] p);
    if (lo == 16'd0) return 1'b1;
    return p >= lo && p <= hi;
  endfunction

  always_comb begin
    m      = v6_q ? '1 : 64'h0000_0000_FFFF_FFFF;
    hm     = v6_q ? '1 : 64'd0;
    rp     = w_q[0][3:2];
    src_ok = addr_ok(sh_q, sl_q, w_q[2] & hm, w_q[3] & m, w_q[4] & hm, w_q[5] & m);
    dst_ok = addr_ok(dh_q, dl_q, w_q[6] & hm, w_q[7] & m, w_q[8] & hm, w_q[9] & m);
    sp_ok  = port_in(w_q[1][15:0], w_q[1][31:16], sp_q);
    dp_ok  = port_in(w_q[1][47:32], w_q[1][63:48], dp_q);
    sts_o.hit = (w_q[0][0] == v6_q) && (w_q[0][1] == dir_q) &&
                (rp == ProtoAny || rp == proto_q) && src_ok && dst_ok && sp_ok && dp_ok;
  end

  logic [2:0] act;
  always_comb begin
    act = w_q[0][6:4];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      action_o            <= ActAllow;
      proxy_ip4_o         <= '0;
      proxy_port_o        <= '0;
      ip6_given_o         <= 1'b0;
      redirect_ip6_high_o <= '0;
      redirect_ip6_low_o  <= '0;
    end else if (cmd_i.hit_sel) begin
      action_o            <= act;
      proxy_ip4_o         <= '0;
      proxy_port_o        <= '0;
      ip6_given_o         <= 1'b0;
      redirect_ip6_high_o <= '0;
      redirect_ip6_low_o  <= '0;
      if (act > ActConnect) begin
        action_o <= ActDrop;
      end else if (act == ActRedirect && v6_q) begin
        ip6_given_o         <= 1'b1;
        redirect_ip6_high_o <= w_q[10];
        redirect_ip6_low_o  <= w_q[11];
        proxy_port_o        <= w_q[12][47:32];
      end else if (act == ActRedirect || act == ActSocks5 || act == ActConnect) begin
        proxy_ip4_o  <= w_q[12][31:0];
        proxy_port_o <= w_q[12][47:32];
      end
    end
  end

endmodule

// ===== sv/fmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmc_ctrl
// sequencer: stages rule words one per cycle and walks rules in order
// ----------------------------------------------------------------------------
module fmc_ctrl import fmc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [AddrW:0]      addr_i,
  input  logic [CountW-1:0]   rule_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cmd_t                cmd_o,
  input  sts_t                sts_i,
  output logic [RuleIdxW-1:0] rule_o
);

  state_e               state_q, state_d;
  logic [RuleIdxW:0]    rule_q, rule_d, n_q, n_d;
  logic [WordIdxW:0]    word_q, word_d;
  logic                 ov_q, ov_d;
  logic                 acc;

  assign rule_o      = rule_q[RuleIdxW-1:0];
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rule_q  <= '0;
      n_q     <= '0;
      word_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rule_q  <= rule_d;
      n_q     <= n_d;
      word_q  <= word_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    rule_d     = rule_q;
    n_d        = n_q;
    word_d     = word_q;
    ov_d       = ov_q && !out_ready_i;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    acc        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // hold input while a result waits so the result registers stay put
        in_ready_o = !ov_q;
        acc        = in_valid_i && !ov_q;
        if (acc && mode_i) begin
          cmd_o.write = (addr_i < (AddrW+1)'(TableDepth));
        end else if (acc) begin
          cmd_o.start = 1'b1;
          cmd_o.clear = 1'b1;
          rule_d      = '0;
          n_d = (rule_count_i > CountW'(MaxRules)) ? (RuleIdxW+1)'(MaxRules)
                                                  : (RuleIdxW+1)'(rule_count_i);
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (rule_q == n_q) begin
          state_d = ST_OUT;
        end else begin
          word_d  = '0;
          state_d = ST_WORD;
        end
      end
      ST_WORD: begin
        cmd_o.rd_en   = (word_q < 13);
        cmd_o.word    = word_q[WordIdxW-1:0];
        cmd_o.capture = 1'b1;
        word_d        = word_q + 1'b1;
        if (word_q == 14) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.hit) begin
          cmd_o.hit_sel = 1'b1;
          state_d       = ST_OUT;
        end else begin
          rule_d  = rule_q + 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/first_match_packet_rule_classifier.sv =====
// a table write is taken when the item is accepted; a lookup walks the rules in order
// and returns the first hit's action, or allow when no rule hits
// throughput: one item at a time, held off while a result waits; each rule passes
// through a load state, word states that read its 13 words through the registered
// memory, and a compare state
// reset clears control state and rule_count; the rule table is not cleared
// ----------------------------------------------------------------------------
// first_match_packet_rule_classifier
// first-match five-tuple classifier over a rule table written by items
// ----------------------------------------------------------------------------
module first_match_packet_rule_classifier import fmc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [5:0]   cfg_wdata_i,   // rule_count
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic         s_axis_tuser,  // mode
  // is_ipv6, direction, protocol, src_addr_high, src_addr_low,
  // dst_addr_high, dst_addr_low, src_port, dst_port, table_word_address,
  // write_data
  input  logic [367:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // action, proxy ip4, proxy port, ip6 given,
  // redirect_ip6_high, redirect_ip6_low
  output logic [183:0] m_axis_tdata
);

  logic [CountW-1:0]   rule_count_q;
  cmd_t                cmd;
  sts_t                sts;
  logic [RuleIdxW-1:0] rule;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q <= '0;
    end else if (cfg_we_i) begin
      rule_count_q <= cfg_wdata_i;
    end
  end

  fmc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .mode_i       (s_axis_tuser),
    .addr_i       ({1'b0, s_axis_tdata[300:292]}),
    .rule_count_i (rule_count_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .cmd_o        (cmd),
    .sts_i        (sts),
    .rule_o       (rule)
  );

  fmc_datapath u_dp (
    .clk_i               (clk_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .rule_i              (rule),
    .waddr_i             (s_axis_tdata[300:292]),
    .wdata_i             (s_axis_tdata[364:301]),
    .is_ipv6_i           (s_axis_tdata[0]),
    .direction_i         (s_axis_tdata[1]),
    .protocol_i          (s_axis_tdata[3:2]),
    .src_addr_high_i     (s_axis_tdata[67:4]),
    .src_addr_low_i      (s_axis_tdata[131:68]),
    .dst_addr_high_i     (s_axis_tdata[195:132]),
    .dst_addr_low_i      (s_axis_tdata[259:196]),
    .src_port_i          (s_axis_tdata[275:260]),
    .dst_port_i          (s_axis_tdata[291:276]),
    .action_o            (m_axis_tdata[2:0]),
    .proxy_ip4_o         (m_axis_tdata[34:3]),
    .proxy_port_o        (m_axis_tdata[50:35]),
    .ip6_given_o         (m_axis_tdata[51]),
    .redirect_ip6_high_o (m_axis_tdata[115:52]),
    .redirect_ip6_low_o  (m_axis_tdata[179:116])
  );

  assign m_axis_tdata[183:180] = 4'd0;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the first-match packet rule classifier: fills the
// rule table through the item stream, runs directed and random lookups over
// several rule counts, and checks every result against a local classifier
// ----------------------------------------------------------------------------
module tb import fmc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ActReject = 3'd2;
  localparam logic [2:0] ActBad    = 3'd7;
  localparam logic [1:0] ProtoTcp  = 2'd0;
  localparam logic [1:0] ProtoUdp  = 2'd1;
  localparam logic [1:0] ProtoIcmp = 2'd2;

  typedef struct {
    logic        mode;
    logic        is_ipv6;
    logic        direction;
    logic [1:0]  protocol;
    logic [63:0] src_hi, src_lo, dst_hi, dst_lo;
    logic [15:0] src_port, dst_port;
    logic [8:0]  waddr;
    logic [63:0] wdata;
  } pkt_t;

  typedef struct {
    logic [2:0]  action;
    logic [31:0] ip4;
    logic [15:0] port;
    logic        has6;
    logic [63:0] ip6_hi, ip6_lo;
  } verdict_t;

  typedef logic [63:0] rule_t [16];

  class rule_scoreboard;
    logic [63:0] table_q [TableDepth];
    logic [5:0]  rule_count;
    verdict_t    verdict_q[$];
    int          errors;

    function new();
      rule_count = '0;
      errors = 0;
    endfunction

    function automatic bit addr_hit(logic [127:0] a, logic [127:0] r, logic [127:0] m);
      if (m == '0) return 1'b1;
      return (a & m) == (r & m);
    endfunction

    function automatic bit port_hit(logic [31:0] rng, logic [15:0] p);
      if (rng[15:0] == '0) return 1'b1;
      return p >= rng[15:0] && p <= rng[31:16];
    endfunction

    function automatic verdict_t classify(pkt_t p);
      verdict_t v;
      logic [63:0] sh, sl, dh, dl, hm, lm, w0;
      int n, b;
      v = '{ActAllow, '0, '0, 1'b0, '0, '0};
      sh = p.src_hi; sl = p.src_lo; dh = p.dst_hi; dl = p.dst_lo;
      if (!p.is_ipv6) begin
        sh = '0; dh = '0; sl[63:32] = '0; dl[63:32] = '0;
      end
      hm = p.is_ipv6 ? '1 : '0;
      lm = p.is_ipv6 ? '1 : 64'hffff_ffff;
      n = rule_count > MaxRules ? MaxRules : rule_count;
      for (int i = 0; i < n; i++) begin
        b = i * WordsPerRule;
        w0 = table_q[b];
        if (w0[0] != p.is_ipv6 || w0[1] != p.direction) continue;
        if (w0[3:2] != ProtoAny && w0[3:2] != p.protocol) continue;
        if (!addr_hit({sh, sl}, {table_q[b+2] & hm, table_q[b+3] & lm},
                      {table_q[b+4] & hm, table_q[b+5] & lm})) continue;
        if (!addr_hit({dh, dl}, {table_q[b+6] & hm, table_q[b+7] & lm},
                      {table_q[b+8] & hm, table_q[b+9] & lm})) continue;
        if (!port_hit(table_q[b+1][31:0], p.src_port)) continue;
        if (!port_hit(table_q[b+1][63:32], p.dst_port)) continue;
        v.action = w0[6:4];
        if (v.action > ActConnect) begin
          v.action = ActDrop;
        end else if (v.action == ActRedirect && p.is_ipv6) begin
          v.has6 = 1'b1;
          v.ip6_hi = table_q[b+10];
          v.ip6_lo = table_q[b+11];
          v.port = table_q[b+12][47:32];
        end else if (v.action >= ActRedirect) begin
          v.ip4 = table_q[b+12][31:0];
          v.port = table_q[b+12][47:32];
        end
        break;
      end
      return v;
    endfunction

    function void note(pkt_t p);
      if (p.mode) table_q[p.waddr] = p.wdata;
      else verdict_q.push_back(classify(p));
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check(verdict_t got);
      verdict_t exp;
      if (verdict_q.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      exp = verdict_q.pop_front();
      if (got.action !== exp.action)
        report($sformatf("action got %0d exp %0d", got.action, exp.action));
      if (got.ip4 !== exp.ip4)
        report($sformatf("proxy ip4 got %h exp %h", got.ip4, exp.ip4));
      if (got.port !== exp.port)
        report($sformatf("proxy port got %h exp %h", got.port, exp.port));
      if (got.has6 !== exp.has6)
        report($sformatf("ip6 given got %b exp %b", got.has6, exp.has6));
      if (got.ip6_hi !== exp.ip6_hi)
        report($sformatf("redirect_ip6_high got %h exp %h", got.ip6_hi, exp.ip6_hi));
      if (got.ip6_lo !== exp.ip6_lo)
        report($sformatf("redirect_ip6_low got %h exp %h", got.ip6_lo, exp.ip6_lo));
    endtask
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [5:0]   cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic         s_axis_tuser;
  logic [367:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [183:0] m_axis_tdata;

  rule_scoreboard sb;
  bit no_idle;
  int out_stall;
  rule_t rules [MaxRules];

  first_match_packet_rule_classifier dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [127:0] rand_mask(int bits);
    int k, len;
    k = $urandom_range(3);
    if (k == 0) return '0;
    if (k == 1) return {128{1'b1}} >> (128 - bits);
    len = $urandom_range(bits, 1);
    return (~({128{1'b1}} >> len)) >> (128 - bits);
  endfunction

  function automatic logic [31:0] rand_range();
    logic [15:0] lo, hi;
    int k;
    k = $urandom_range(9);
    lo = 16'($urandom); hi = 16'($urandom);
    if (k < 3) return {hi, 16'd0};
    if (k == 3) begin
      if (lo < hi) return {lo, hi};
      if (lo == hi) return {lo, lo + 16'd1};
      return {hi, lo};
    end
    if (lo == 16'd0) lo = 16'd1;
    if (hi < lo) hi = lo + 16'($urandom_range(500));
    if (hi < lo) hi = 16'hffff;
    return {hi, lo};
  endfunction

  function automatic rule_t make_rule(logic fam, logic dir, logic [1:0] proto,
                                      logic [2:0] act);
    rule_t w;
    logic [127:0] m;
    int bits;
    bits = fam ? 128 : 32;
    foreach (w[i]) w[i] = rand64();
    w[0][6:0] = {act, proto, dir, fam};
    w[1] = {rand_range(), rand_range()};
    m = rand_mask(bits);
    if (fam) {w[4], w[5]} = m;
    else w[5][31:0] = m[31:0];
    m = rand_mask(bits);
    if (fam) {w[8], w[9]} = m;
    else w[9][31:0] = m[31:0];
    return w;
  endfunction

  function automatic rule_t any_rule();
    return make_rule(1'($urandom_range(1)), 1'($urandom_range(1)),
                     2'($urandom_range(3)), 3'($urandom_range(7)));
  endfunction

  function automatic logic [127:0] fit_addr(logic [127:0] a, logic [127:0] m);
    return (a & m) | ({rand64(), rand64()} & ~m);
  endfunction

  function automatic logic [15:0] fit_port(logic [31:0] rng);
    if (rng[15:0] == 0 || rng[15:0] > rng[31:16]) return 16'($urandom);
    return 16'($urandom_range(rng[31:16], rng[15:0]));
  endfunction

  function automatic pkt_t noise_pkt();
    pkt_t p;
    p.mode = 1'b0;
    p.is_ipv6 = 1'($urandom_range(1));
    p.direction = 1'($urandom_range(1));
    p.protocol = 2'($urandom_range(3));
    p.src_hi = rand64(); p.src_lo = rand64();
    p.dst_hi = rand64(); p.dst_lo = rand64();
    p.src_port = 16'($urandom); p.dst_port = 16'($urandom);
    p.waddr = 9'($urandom); p.wdata = rand64();
    return p;
  endfunction

  function automatic pkt_t hit_pkt(int idx);
    pkt_t p;
    rule_t w;
    logic [127:0] a;
    w = rules[idx];
    p = noise_pkt();
    p.is_ipv6 = w[0][0];
    p.direction = w[0][1];
    if (w[0][3:2] != ProtoAny) p.protocol = w[0][3:2];
    if (p.is_ipv6) begin
      {p.src_hi, p.src_lo} = fit_addr({w[2], w[3]}, {w[4], w[5]});
      {p.dst_hi, p.dst_lo} = fit_addr({w[6], w[7]}, {w[8], w[9]});
    end else begin
      a = fit_addr({96'd0, w[3][31:0]}, {96'd0, w[5][31:0]});
      p.src_lo[31:0] = a[31:0];
      a = fit_addr({96'd0, w[7][31:0]}, {96'd0, w[9][31:0]});
      p.dst_lo[31:0] = a[31:0];
    end
    p.src_port = fit_port(w[1][31:0]);
    p.dst_port = fit_port(w[1][63:32]);
    return p;
  endfunction

  task automatic send_item(pkt_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= p.mode;
    s_axis_tdata <= {3'd0, p.wdata, p.waddr, p.dst_port, p.src_port, p.dst_lo,
                     p.dst_hi, p.src_lo, p.src_hi, p.protocol, p.direction,
                     p.is_ipv6};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note(p);
  endtask

  task automatic write_word(int addr, logic [63:0] data);
    pkt_t p;
    p = noise_pkt();
    p.mode = 1'b1;
    p.waddr = 9'(addr);
    p.wdata = data;
    send_item(p);
  endtask

  task automatic write_rule(int idx, rule_t w);
    rules[idx] = w;
    for (int i = 0; i < WordsPerRule; i++) write_word(idx * WordsPerRule + i, w[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.verdict_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_count(logic [5:0] n);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    sb.rule_count = n;
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check('{m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[50:35],
                   m_axis_tdata[51], m_axis_tdata[115:52], m_axis_tdata[179:116]});
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(3) == 0) out_stall <= pick_gap();
      end
    end
  end

  initial begin
    pkt_t p;
    int n, idx, r;
    logic [5:0] counts [8] = '{6'd1, 6'd32, 6'd63, 6'd5, 6'd17, 6'd0, 6'd33, 6'd12};
    sb = new();
    no_idle = 1'b0;
    out_stall = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // table fill, the first rules hand-shaped
    for (int i = 8; i < MaxRules; i++) write_rule(i, any_rule());
    write_rule(0, make_rule(1'b0, 1'b0, ProtoTcp, ActRedirect));
    write_rule(1, make_rule(1'b1, 1'b1, ProtoAny, ActRedirect));
    write_rule(2, make_rule(1'b0, 1'b1, ProtoUdp, ActBad));
    write_rule(3, make_rule(1'b1, 1'b0, ProtoIcmp, ActSocks5));
    write_rule(4, make_rule(1'b0, 1'b0, ProtoAny, ActConnect));
    write_rule(5, make_rule(1'b1, 1'b0, ProtoUdp, ActReject));
    write_rule(6, make_rule(1'b0, 1'b1, ProtoAny, ActDrop));
    write_rule(7, make_rule(1'b1, 1'b1, ProtoTcp, ActAllow));

    send_item(hit_pkt(0));
    set_count(6'd8);
    for (int i = 0; i < 8; i++) send_item(hit_pkt(i));
    p = hit_pkt(1); p.protocol = ProtoAny; send_item(p);
    p = hit_pkt(3); p.protocol = ProtoAny; send_item(p);
    p = noise_pkt(); p.is_ipv6 = 1'b0; p.direction = 1'b0; p.protocol = ProtoTcp;
    p.src_hi = '0; p.src_lo = '0; p.dst_hi = '0; p.dst_lo = '0;
    p.src_port = '0; p.dst_port = '0; send_item(p);
    p.is_ipv6 = 1'b1; p.direction = 1'b1; p.protocol = ProtoAny;
    p.src_hi = '1; p.src_lo = '1; p.dst_hi = '1; p.dst_lo = '1;
    p.src_port = '1; p.dst_port = '1; send_item(p);

    for (int ph = 0; ph < 8; ph++) begin
      set_count(counts[ph]);
      no_idle = (ph % 3 == 2);
      n = counts[ph] > MaxRules ? MaxRules : counts[ph];
      for (int k = 0; k < 25; k++) begin
        r = $urandom_range(99);
        if (r < 6) begin
          write_word($urandom_range(TableDepth - 1), rand64());
        end else if (r < 8) begin
          idx = $urandom_range(MaxRules - 1);
          write_rule(idx, any_rule());
        end else if (r < 70) begin
          idx = $urandom_range(n > 0 ? n - 1 : MaxRules - 1);
          send_item(hit_pkt(idx));
        end else begin
          send_item(noise_pkt());
        end
      end
    end
    no_idle = 1'b0;
    drain();
    repeat (600) @(posedge clk_i);
    if (sb.verdict_q.size() > 0) sb.report("expected results left over");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fmc_pkg.sv
sv/fmc_datapath.sv
sv/fmc_ctrl.sv
sv/first_match_packet_rule_classifier.sv
tb/tb.sv
